/* design/tcc_pkg.sv */
package tcc_pkg;

	// Result fields are 32 bits wide.
	localparam int OUT_W = 32;
	// The quotient magnitude is kept to 41 bits; anything above 2^40 clips.
	localparam int QBITS = 41;
	// The root of the squared radius fits in 35 bits.
	localparam int ROOT_BITS = 35;
	localparam int RAD_BITS = 2 * ROOT_BITS;

	typedef struct packed {
		logic degen;
		logic neg_x;
		logic neg_y;
	} tcc_flags_t;

endpackage

/* design/tcc_front.sv */
module tcc_front #(
	parameter int C = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [C-1:0] x0,
	input  logic signed [C-1:0] y0,
	input  logic signed [C-1:0] x1,
	input  logic signed [C-1:0] y1,
	input  logic signed [C-1:0] x2,
	input  logic signed [C-1:0] y2,
	output logic                out_valid,
	output logic [3*C+2:0]      nmag_x,
	output logic [3*C+2:0]      nmag_y,
	output logic [2*C+2:0]      dmag,
	output tcc_pkg::tcc_flags_t flags,
	output logic signed [C-1:0] base_x,
	output logic signed [C-1:0] base_y
);
	import tcc_pkg::*;

	localparam int UW  = C + 1;
	localparam int PW  = 2 * UW;
	localparam int SW  = 2 * C + 2;
	localparam int HW  = C + 1;
	localparam int MW  = UW + HW + 1;
	localparam int NW  = 3 * C + 4;
	localparam int DW  = 2 * C + 4;
	localparam int NMW = 3 * C + 3;
	localparam int DMW = 2 * C + 3;

	logic [7:1] v;

	logic signed [C-1:0] bx_s1, by_s1, bx_s2, by_s2, bx_s3, by_s3, bx_s4, by_s4;
	logic signed [C-1:0] bx_s5, by_s5, bx_s6, by_s6, bx_s7, by_s7;

	logic signed [UW-1:0] ux_s1, uy_s1, wx_s1, wy_s1;
	logic signed [UW-1:0] ux_s2, uy_s2, wx_s2, wy_s2;
	logic signed [UW-1:0] ux_s3, uy_s3, wx_s3, wy_s3;
	logic signed [PW-1:0] uxx_s2, uyy_s2, wxx_s2, wyy_s2, c1_s2, c2_s2;
	logic [SW-1:0]        su_s3, sw_s3;
	logic signed [DW-1:0] d_s3, d_s4, d_s5, d_s6;
	logic signed [MW-1:0] al_s4, ah_s4, bl_s4, bh_s4, cl_s4, ch_s4, el_s4, eh_s4;
	logic signed [NW-1:0] pa_s5, pb_s5, pc_s5, pe_s5;
	logic signed [NW-1:0] numx_s6, numy_s6;
	logic [NMW-1:0]       nmx_s7, nmy_s7;
	logic [DMW-1:0]       dm_s7;
	tcc_flags_t           fl_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			v <= {v[6:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		// Stage 1: move vertex 0 to the origin.
		ux_s1 <= UW'(x1) - UW'(x0);
		uy_s1 <= UW'(y1) - UW'(y0);
		wx_s1 <= UW'(x2) - UW'(x0);
		wy_s1 <= UW'(y2) - UW'(y0);
		bx_s1 <= x0;
		by_s1 <= y0;

		// Stage 2: squares and cross products.
		uxx_s2 <= ux_s1 * ux_s1;
		uyy_s2 <= uy_s1 * uy_s1;
		wxx_s2 <= wx_s1 * wx_s1;
		wyy_s2 <= wy_s1 * wy_s1;
		c1_s2  <= ux_s1 * wy_s1;
		c2_s2  <= uy_s1 * wx_s1;
		ux_s2  <= ux_s1;
		uy_s2  <= uy_s1;
		wx_s2  <= wx_s1;
		wy_s2  <= wy_s1;
		bx_s2  <= bx_s1;
		by_s2  <= by_s1;

		// Stage 3: squared lengths and the determinant.
		su_s3 <= $unsigned(uxx_s2) + $unsigned(uyy_s2);
		sw_s3 <= $unsigned(wxx_s2) + $unsigned(wyy_s2);
		d_s3  <= (DW'(c1_s2) - DW'(c2_s2)) <<< 1;
		ux_s3 <= ux_s2;
		uy_s3 <= uy_s2;
		wx_s3 <= wx_s2;
		wy_s3 <= wy_s2;
		bx_s3 <= bx_s2;
		by_s3 <= by_s2;

		// Stage 4: numerator products, split into low and high halves of the length.
		al_s4 <= MW'(wy_s3) * $signed({1'b0, su_s3[HW-1:0]});
		ah_s4 <= MW'(wy_s3) * $signed({1'b0, su_s3[SW-1:HW]});
		bl_s4 <= MW'(uy_s3) * $signed({1'b0, sw_s3[HW-1:0]});
		bh_s4 <= MW'(uy_s3) * $signed({1'b0, sw_s3[SW-1:HW]});
		cl_s4 <= MW'(ux_s3) * $signed({1'b0, sw_s3[HW-1:0]});
		ch_s4 <= MW'(ux_s3) * $signed({1'b0, sw_s3[SW-1:HW]});
		el_s4 <= MW'(wx_s3) * $signed({1'b0, su_s3[HW-1:0]});
		eh_s4 <= MW'(wx_s3) * $signed({1'b0, su_s3[SW-1:HW]});
		d_s4  <= d_s3;
		bx_s4 <= bx_s3;
		by_s4 <= by_s3;

		// Stage 5: recombine the partial products.
		pa_s5 <= (NW'(ah_s4) <<< HW) + NW'(al_s4);
		pb_s5 <= (NW'(bh_s4) <<< HW) + NW'(bl_s4);
		pc_s5 <= (NW'(ch_s4) <<< HW) + NW'(cl_s4);
		pe_s5 <= (NW'(eh_s4) <<< HW) + NW'(el_s4);
		d_s5  <= d_s4;
		bx_s5 <= bx_s4;
		by_s5 <= by_s4;

		// Stage 6: numerators.
		numx_s6 <= pa_s5 - pb_s5;
		numy_s6 <= pc_s5 - pe_s5;
		d_s6    <= d_s5;
		bx_s6   <= bx_s5;
		by_s6   <= by_s5;

		// Stage 7: magnitudes and quotient signs for the dividers.
		nmx_s7 <= numx_s6[NW-1] ? NMW'(-numx_s6) : NMW'(numx_s6);
		nmy_s7 <= numy_s6[NW-1] ? NMW'(-numy_s6) : NMW'(numy_s6);
		dm_s7  <= d_s6[DW-1] ? DMW'(-d_s6) : DMW'(d_s6);
		fl_s7.degen <= (d_s6 == '0);
		fl_s7.neg_x <= numx_s6[NW-1] ^ d_s6[DW-1];
		fl_s7.neg_y <= numy_s6[NW-1] ^ d_s6[DW-1];
		bx_s7  <= bx_s6;
		by_s7  <= by_s6;
	end

	assign out_valid = v[7];
	assign nmag_x    = nmx_s7;
	assign nmag_y    = nmy_s7;
	assign dmag      = dm_s7;
	assign flags     = fl_s7;
	assign base_x    = bx_s7;
	assign base_y    = by_s7;

endmodule

/* design/tcc_div.sv */
module tcc_div #(
	parameter int NMW = 51,
	parameter int DMW = 35,
	parameter int TW  = 35
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [NMW-1:0]              nx,
	input  logic [NMW-1:0]              ny,
	input  logic [DMW-1:0]              dm,
	input  logic [TW-1:0]               tag_in,
	output logic                        out_valid,
	output logic [tcc_pkg::QBITS-1:0]   qx,
	output logic [tcc_pkg::QBITS-1:0]   qy,
	output logic                        sat_x,
	output logic                        sat_y,
	output logic [TW-1:0]               tag_out
);
	import tcc_pkg::*;

	localparam int CW = (NMW > DMW + QBITS) ? NMW : DMW + QBITS;

	logic              v_s    [0:QBITS];
	logic [CW-1:0]     rx_s   [0:QBITS];
	logic [CW-1:0]     ry_s   [0:QBITS];
	logic [QBITS-1:0]  qx_s   [0:QBITS];
	logic [QBITS-1:0]  qy_s   [0:QBITS];
	logic [DMW-1:0]    dm_s   [0:QBITS];
	logic              sx_s   [0:QBITS];
	logic              sy_s   [0:QBITS];
	logic [TW-1:0]     tag_s  [0:QBITS];
	logic [CW-1:0]     lim;

	// A quotient above 2^40 means the numerator reaches (2^40 + 1) times the divisor.
	assign lim = (CW'(dm) << (QBITS - 1)) + CW'(dm);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rx_s[0]  <= CW'(nx);
		ry_s[0]  <= CW'(ny);
		qx_s[0]  <= '0;
		qy_s[0]  <= '0;
		dm_s[0]  <= dm;
		sx_s[0]  <= (CW'(nx) >= lim);
		sy_s[0]  <= (CW'(ny) >= lim);
		tag_s[0] <= tag_in;
	end

	for (genvar k = 1; k <= QBITS; k++) begin : g_step
		localparam int B = QBITS - k;
		logic [CW-1:0] trial;
		assign trial = CW'(dm_s[k-1]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rx_s[k-1] >= trial) begin
				rx_s[k] <= rx_s[k-1] - trial;
				qx_s[k] <= qx_s[k-1] | (QBITS'(1) << B);
			end else begin
				rx_s[k] <= rx_s[k-1];
				qx_s[k] <= qx_s[k-1];
			end
			if (ry_s[k-1] >= trial) begin
				ry_s[k] <= ry_s[k-1] - trial;
				qy_s[k] <= qy_s[k-1] | (QBITS'(1) << B);
			end else begin
				ry_s[k] <= ry_s[k-1];
				qy_s[k] <= qy_s[k-1];
			end
			dm_s[k]  <= dm_s[k-1];
			sx_s[k]  <= sx_s[k-1];
			sy_s[k]  <= sy_s[k-1];
			tag_s[k] <= tag_s[k-1];
		end
	end

	assign out_valid = v_s[QBITS];
	assign qx        = qx_s[QBITS];
	assign qy        = qy_s[QBITS];
	assign sat_x     = sx_s[QBITS];
	assign sat_y     = sy_s[QBITS];
	assign tag_out   = tag_s[QBITS];

endmodule

/* design/tcc_sqrt.sv */
module tcc_sqrt #(
	parameter int TW = 66
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [tcc_pkg::RAD_BITS-1:0]      radicand,
	input  logic [TW-1:0]                     tag_in,
	output logic                              out_valid,
	output logic [tcc_pkg::ROOT_BITS-1:0]     root,
	output logic [TW-1:0]                     tag_out
);
	import tcc_pkg::*;

	logic                  v_s   [1:ROOT_BITS];
	logic [RAD_BITS-1:0]   rem_s [1:ROOT_BITS];
	logic [ROOT_BITS-1:0]  rt_s  [1:ROOT_BITS];
	logic [TW-1:0]         tag_s [1:ROOT_BITS];

	// The remainder holds radicand minus root squared; each step tries one more root bit.
	for (genvar k = 1; k <= ROOT_BITS; k++) begin : g_step
		localparam int B = ROOT_BITS - k;
		logic                  v_p;
		logic [RAD_BITS-1:0]   rem_p;
		logic [ROOT_BITS-1:0]  rt_p;
		logic [TW-1:0]         tag_p;
		logic [RAD_BITS-1:0]   delta;

		if (k == 1) begin : g_first
			assign v_p   = in_valid;
			assign rem_p = radicand;
			assign rt_p  = '0;
			assign tag_p = tag_in;
		end else begin : g_next
			assign v_p   = v_s[k-1];
			assign rem_p = rem_s[k-1];
			assign rt_p  = rt_s[k-1];
			assign tag_p = tag_s[k-1];
		end

		assign delta = (RAD_BITS'(rt_p) << (B + 1)) + (RAD_BITS'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (rem_p >= delta) begin
				rem_s[k] <= rem_p - delta;
				rt_s[k]  <= rt_p | (ROOT_BITS'(1) << B);
			end else begin
				rem_s[k] <= rem_p;
				rt_s[k]  <= rt_p;
			end
			tag_s[k] <= tag_p;
		end
	end

	assign out_valid = v_s[ROOT_BITS];
	assign root      = rt_s[ROOT_BITS];
	assign tag_out   = tag_s[ROOT_BITS];

endmodule

/* design/triangle_circumcircle_core.sv */
// Circumcircle of one 2D triangle per beat. A triangle is taken whenever start is high;
// busy never rises, so a new triangle may enter on every clock. Each triangle yields
// one result beat, marked by done, in order, after passing through registered steps:
// products and sums, the pipelined 41-bit quotient, forming the center and the squared
// radius, the pipelined square root, and an output register. The receiver cannot hold
// results off. Collinear vertices give zeros with degenerate set; a clipped center or
// radius sets saturated.
module triangle_circumcircle_core #(
	parameter int COORD_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [COORD_BITS-1:0]   x0,
	input  logic signed [COORD_BITS-1:0]   y0,
	input  logic signed [COORD_BITS-1:0]   x1,
	input  logic signed [COORD_BITS-1:0]   y1,
	input  logic signed [COORD_BITS-1:0]   x2,
	input  logic signed [COORD_BITS-1:0]   y2,
	output logic                           done,
	output logic signed [tcc_pkg::OUT_W-1:0] center_x,
	output logic signed [tcc_pkg::OUT_W-1:0] center_y,
	output logic [tcc_pkg::OUT_W-1:0]      radius,
	output logic                           degenerate,
	output logic                           saturated
);
	import tcc_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int NMW = 3 * C + 3;
	localparam int DMW = 2 * C + 3;
	localparam int DTW = 3 + 2 * C;
	localparam int QW  = QBITS + 2;
	localparam int RW  = OUT_W + 1;
	localparam int SQW = 2 * RW;
	localparam int STW = 2 * OUT_W + 2;
	localparam logic signed [QW-1:0] CMAX = (QW'(1) <<< (OUT_W - 1)) - QW'(1);
	localparam logic signed [QW-1:0] CMIN = -(QW'(1) <<< (OUT_W - 1));

	logic                   f_valid;
	logic [NMW-1:0]         f_nx, f_ny;
	logic [DMW-1:0]         f_dm;
	tcc_flags_t             f_flags;
	logic signed [C-1:0]    f_bx, f_by;

	logic                   d_valid;
	logic [QBITS-1:0]       d_qx, d_qy;
	logic                   d_sx, d_sy;
	logic [DTW-1:0]         d_tag;
	tcc_flags_t             d_flags;
	logic signed [C-1:0]    d_bx, d_by;
	logic signed [QW-1:0]   vx, vy;

	logic [4:1]             vc;
	logic signed [OUT_W-1:0] cx_c1, cy_c1, cx_c2, cy_c2, cx_c3, cy_c3, cx_c4, cy_c4;
	logic                   sat_c1, sat_c2, sat_c3, sat_c4;
	logic                   dg_c1, dg_c2, dg_c3, dg_c4;
	logic signed [C-1:0]    bx_c1, by_c1;
	logic signed [RW-1:0]   rx_c2, ry_c2;
	logic signed [SQW-1:0]  rxx_c3, ryy_c3;
	logic [RAD_BITS-1:0]    s_c4;

	logic                   r_valid;
	logic [ROOT_BITS-1:0]   r_root;
	logic [STW-1:0]         r_tag;
	logic                   r_dg, r_sat;
	logic signed [OUT_W-1:0] r_cx, r_cy;
	logic                   r_big;

	assign busy = 1'b0;

	tcc_front #(.C(C)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.x0        (x0),
		.y0        (y0),
		.x1        (x1),
		.y1        (y1),
		.x2        (x2),
		.y2        (y2),
		.out_valid (f_valid),
		.nmag_x    (f_nx),
		.nmag_y    (f_ny),
		.dmag      (f_dm),
		.flags     (f_flags),
		.base_x    (f_bx),
		.base_y    (f_by)
	);

	tcc_div #(.NMW(NMW), .DMW(DMW), .TW(DTW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.nx        (f_nx),
		.ny        (f_ny),
		.dm        (f_dm),
		.tag_in    ({f_flags, f_bx, f_by}),
		.out_valid (d_valid),
		.qx        (d_qx),
		.qy        (d_qy),
		.sat_x     (d_sx),
		.sat_y     (d_sy),
		.tag_out   (d_tag)
	);

	assign d_flags = d_tag[DTW-1:2*C];
	assign d_bx    = d_tag[2*C-1:C];
	assign d_by    = d_tag[C-1:0];

	assign vx = (d_flags.neg_x ? -$signed({2'b00, d_qx}) : $signed({2'b00, d_qx})) + QW'(d_bx);
	assign vy = (d_flags.neg_y ? -$signed({2'b00, d_qy}) : $signed({2'b00, d_qy})) + QW'(d_by);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc <= '0;
		end else begin
			vc <= {vc[3:1], d_valid};
		end
	end

	always_ff @(posedge clk) begin
		// Apply the sign, move back by vertex 0 and clip to the output range.
		if (d_sx) begin
			cx_c1 <= d_flags.neg_x ? OUT_W'(CMIN) : OUT_W'(CMAX);
		end else if (vx > CMAX) begin
			cx_c1 <= OUT_W'(CMAX);
		end else if (vx < CMIN) begin
			cx_c1 <= OUT_W'(CMIN);
		end else begin
			cx_c1 <= OUT_W'(vx);
		end
		if (d_sy) begin
			cy_c1 <= d_flags.neg_y ? OUT_W'(CMIN) : OUT_W'(CMAX);
		end else if (vy > CMAX) begin
			cy_c1 <= OUT_W'(CMAX);
		end else if (vy < CMIN) begin
			cy_c1 <= OUT_W'(CMIN);
		end else begin
			cy_c1 <= OUT_W'(vy);
		end
		sat_c1 <= d_sx | d_sy | (vx > CMAX) | (vx < CMIN) | (vy > CMAX) | (vy < CMIN);
		dg_c1  <= d_flags.degen;
		bx_c1  <= d_bx;
		by_c1  <= d_by;

		rx_c2  <= RW'(cx_c1) - RW'(bx_c1);
		ry_c2  <= RW'(cy_c1) - RW'(by_c1);
		cx_c2  <= cx_c1;
		cy_c2  <= cy_c1;
		sat_c2 <= sat_c1;
		dg_c2  <= dg_c1;

		rxx_c3 <= rx_c2 * rx_c2;
		ryy_c3 <= ry_c2 * ry_c2;
		cx_c3  <= cx_c2;
		cy_c3  <= cy_c2;
		sat_c3 <= sat_c2;
		dg_c3  <= dg_c2;

		s_c4   <= RAD_BITS'($unsigned(rxx_c3)) + RAD_BITS'($unsigned(ryy_c3));
		cx_c4  <= cx_c3;
		cy_c4  <= cy_c3;
		sat_c4 <= sat_c3;
		dg_c4  <= dg_c3;
	end

	tcc_sqrt #(.TW(STW)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vc[4]),
		.radicand  (s_c4),
		.tag_in    ({dg_c4, sat_c4, cx_c4, cy_c4}),
		.out_valid (r_valid),
		.root      (r_root),
		.tag_out   (r_tag)
	);

	assign r_dg  = r_tag[STW-1];
	assign r_sat = r_tag[STW-2];
	assign r_cx  = r_tag[2*OUT_W-1:OUT_W];
	assign r_cy  = r_tag[OUT_W-1:0];
	assign r_big = (r_root[ROOT_BITS-1:OUT_W] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= r_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (r_dg) begin
			center_x   <= '0;
			center_y   <= '0;
			radius     <= '0;
			degenerate <= 1'b1;
			saturated  <= 1'b0;
		end else begin
			center_x   <= r_cx;
			center_y   <= r_cy;
			radius     <= (r_sat || r_big) ? '1 : r_root[OUT_W-1:0];
			degenerate <= 1'b0;
			saturated  <= r_sat | r_big;
		end
	end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tcc_pkg::*;

	localparam int CW = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 120;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		logic signed [OUT_W-1:0] cx;
		logic signed [OUT_W-1:0] cy;
		logic [OUT_W-1:0] rad;
		logic degen;
		logic sat;
	} circle_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	coord_t x0, y0, x1, y1, x2, y2;
	logic done;
	logic signed [OUT_W-1:0] center_x, center_y;
	logic [OUT_W-1:0] radius;
	logic degenerate, saturated;

	circle_t expected_circles[$];
	int accepted_beats;
	int checked_beats;
	int error_count;
	int idle_cycles;
	int degen_seen;
	int sat_seen;

	triangle_circumcircle_core #(.COORD_BITS(CW)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x0(x0), .y0(y0), .x1(x1), .y1(y1), .x2(x2), .y2(y2),
		.done(done), .center_x(center_x), .center_y(center_y), .radius(radius),
		.degenerate(degenerate), .saturated(saturated)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// One axis of the center: base + num / d truncated toward zero, clipped to 32 bits.
	function automatic longint center_coord(input logic signed [127:0] num, input longint d,
			input longint base, inout logic sat);
		logic [127:0] nmag, dmag, q;
		logic neg;
		longint v;
		neg = num[127] != (d < 0);
		nmag = num[127] ? -num : num;
		dmag = (d < 0) ? 128'(-d) : 128'(d);
		q = nmag / dmag;
		if (q > (128'd1 << 40)) begin
			sat = 1'b1;
			return neg ? -64'sd2147483648 : 64'sd2147483647;
		end
		v = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
		v += base;
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic circle_t circumcircle(input coord_t ax, input coord_t ay,
			input coord_t bx, input coord_t by, input coord_t qx, input coord_t qy);
		circle_t r;
		longint ux, uy, wx, wy, su, sw, d, cxl, cyl;
		logic signed [127:0] nx, ny, rx, ry, s;
		logic [127:0] root, c;
		logic sat;
		ux = longint'(bx) - longint'(ax);
		uy = longint'(by) - longint'(ay);
		wx = longint'(qx) - longint'(ax);
		wy = longint'(qy) - longint'(ay);
		su = ux * ux + uy * uy;
		sw = wx * wx + wy * wy;
		d = 2 * (ux * wy - uy * wx);
		r = '{cx: '0, cy: '0, rad: '0, degen: 1'b0, sat: 1'b0};
		if (d == 0) begin
			r.degen = 1'b1;
			return r;
		end
		sat = 1'b0;
		nx = 128'(wy) * 128'(su) - 128'(uy) * 128'(sw);
		ny = 128'(ux) * 128'(sw) - 128'(wx) * 128'(su);
		cxl = center_coord(nx, d, longint'(ax), sat);
		cyl = center_coord(ny, d, longint'(ay), sat);
		if (sat) begin
			r.rad = '1;
		end else begin
			rx = 128'(cxl - longint'(ax));
			ry = 128'(cyl - longint'(ay));
			s = rx * rx + ry * ry;
			root = '0;
			for (int b = 34; b >= 0; b--) begin
				c = root | (128'd1 << b);
				if (c * c <= s) root = c;
			end
			if (root > 128'hFFFF_FFFF) begin
				root = 128'hFFFF_FFFF;
				sat = 1'b1;
			end
			r.rad = root[31:0];
		end
		r.cx = cxl[31:0];
		r.cy = cyl[31:0];
		r.sat = sat;
		return r;
	endfunction

	task automatic report(input string field, input longint got, input longint want);
		$display("mismatch on beat %0d: %s got %0d, expected %0d",
			checked_beats, field, got, want);
		error_count++;
	endtask

	// Inputs only change at the falling edge, so the sampled values are stable here.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			expected_circles.push_back(circumcircle(x0, y0, x1, y1, x2, y2));
			accepted_beats <= accepted_beats + 1;
		end
	end

	always @(posedge clk) begin
		circle_t e;
		if (arst_n && done) begin
			if (expected_circles.size() == 0) begin
				$display("result beat with no triangle outstanding");
				error_count++;
			end else begin
				e = expected_circles.pop_front();
				if (center_x !== e.cx) report("center_x", center_x, e.cx);
				if (center_y !== e.cy) report("center_y", center_y, e.cy);
				if (radius !== e.rad) report("radius", radius, e.rad);
				if (degenerate !== e.degen) report("degenerate", degenerate, e.degen);
				if (saturated !== e.sat) report("saturated", saturated, e.sat);
				if (e.degen) degen_seen++;
				if (e.sat) sat_seen++;
			end
			checked_beats++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(start && !busy) && !done) idle_cycles++;
		else idle_cycles = 0;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", expected_circles.size());
			$display("tb: failure");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_triangle(input coord_t ax, input coord_t ay, input coord_t bx,
			input coord_t by, input coord_t qx, input coord_t qy);
		int seen;
		seen = accepted_beats;
		x0 <= ax; y0 <= ay; x1 <= bx; y1 <= by; x2 <= qx; y2 <= qy;
		start <= 1'b1;
		do @(negedge clk); while (accepted_beats == seen);
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_until_drained();
		start <= 1'b0;
		while (expected_circles.size() != 0) @(negedge clk);
	endtask

	function automatic coord_t rand_coord();
		return coord_t'($urandom());
	endfunction

	task automatic test_directed();
		send_triangle(0, 0, 16, 0, 0, 16);
		send_triangle(0, 0, 0, 0, 0, 0);
		send_triangle(100, 100, 100, 100, 500, -20);
		send_triangle(0, 0, 16, 16, 32, 32);
		send_triangle(-32768, -32768, 32767, 32767, -32768, 32767);
		send_triangle(32767, 32767, -32768, 32767, 32767, -32768);
		send_triangle(-32768, 0, 32767, 0, 0, 32767);
		send_triangle(-32768, -32768, 32767, 32767, 32767, -32768);
		send_triangle(-32768, -32768, 32767, 32767, -32767, -32767);
		send_triangle(-32768, -32768, 32767, 32766, 32766, 32765);
		send_triangle(32767, -32768, -32768, 32767, 1, 0);
		send_triangle(0, 0, 1, 0, 2, 1);
		send_triangle(-1, -1, 1, 1, 1, -1);
		send_triangle(5, 7, 5, 7, 9, 9);
		send_triangle(-32768, 32767, 0, 0, 32767, -32767);
		send_triangle(1000, -2000, -3000, 4000, 7, 11);
		pause_sender(3);
		send_triangle(0, 0, 32767, 1, -32768, 0);
		wait_until_drained();
	endtask

	task automatic send_random_triangle();
		coord_t ax, ay, bx, by, qx, qy;
		int k;
		ax = rand_coord();
		ay = rand_coord();
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				bx = rand_coord(); by = rand_coord(); qx = rand_coord(); qy = rand_coord();
			end
			3, 4, 5: begin
				ax = coord_t'(int'($urandom_range(0, 4000)) - 2000);
				ay = coord_t'(int'($urandom_range(0, 4000)) - 2000);
				bx = ax + coord_t'(int'($urandom_range(0, 512)) - 256);
				by = ay + coord_t'(int'($urandom_range(0, 512)) - 256);
				qx = ax + coord_t'(int'($urandom_range(0, 512)) - 256);
				qy = ay + coord_t'(int'($urandom_range(0, 512)) - 256);
			end
			6: begin
				// Collinear: the third vertex lies on the line through the first two.
				k = $urandom_range(0, 6) - 3;
				bx = ax + coord_t'(int'($urandom_range(0, 200)) - 100);
				by = ay + coord_t'(int'($urandom_range(0, 200)) - 100);
				qx = ax + coord_t'(k * (int'(bx) - int'(ax)));
				qy = ay + coord_t'(k * (int'(by) - int'(ay)));
			end
			7: begin
				// Nearly collinear and long, which drives the center out of range.
				bx = ax + coord_t'(int'($urandom_range(0, 16000)) - 8000);
				by = ay + coord_t'(int'($urandom_range(0, 16000)) - 8000);
				qx = ax + coord_t'(2 * (int'(bx) - int'(ax)))
					+ coord_t'(int'($urandom_range(0, 2)) - 1);
				qy = ay + coord_t'(2 * (int'(by) - int'(ay)))
					+ coord_t'(int'($urandom_range(0, 2)) - 1);
			end
			8: begin
				bx = ax; by = ay; qx = rand_coord(); qy = rand_coord();
			end
			default: begin
				ax = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				bx = $urandom_range(0, 1) ? 16'sh7FFF : rand_coord();
				by = $urandom_range(0, 1) ? 16'sh8000 : rand_coord();
				qx = rand_coord(); qy = $urandom_range(0, 1) ? 16'sh7FFF : rand_coord();
			end
		endcase
		send_triangle(ax, ay, bx, by, qx, qy);
	endtask

	task automatic test_random(input int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_random_triangle();
				sent++;
			end
			if ($urandom_range(0, 30) == 0) wait_until_drained();
			else if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		x0 = '0; y0 = '0; x1 = '0; y1 = '0; x2 = '0; y2 = '0;
		accepted_beats = 0;
		checked_beats = 0;
		error_count = 0;
		idle_cycles = 0;
		degen_seen = 0;
		sat_seen = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(700);
		wait_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d triangles, %0d results checked", accepted_beats, checked_beats);
		$display("collinear cases %0d, clipped cases %0d", degen_seen, sat_seen);
		if (error_count == 0 && expected_circles.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches, %0d results missing", error_count,
				expected_circles.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule
